FILE: rtl/lgbe_pkg.sv
// Shared types and constants for the line gap buffer editor.
`default_nettype none
package lgbe_pkg;

  localparam int unsigned MaxLinesDef     = 64;
  localparam int unsigned LineCapacityDef = 128;
  localparam logic [7:0]  VisLinesReset   = 8'd32;

  typedef enum logic [3:0] {
    KIND_INSERT    = 4'd0,
    KIND_BACKSPACE = 4'd1,
    KIND_LEFT      = 4'd2,
    KIND_RIGHT     = 4'd3,
    KIND_UP        = 4'd4,
    KIND_DOWN      = 4'd5,
    KIND_SPLIT     = 4'd6,
    KIND_JOIN      = 4'd7,
    KIND_GOTO      = 4'd8,
    KIND_READ      = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_EDGE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SLOT,
    S_META,
    S_EXEC,
    S_AUX_SLOT,
    S_AUX_META,
    S_COPY_RD,
    S_COPY_WR,
    S_FIX,
    S_FIX2,
    S_ORD_RD,
    S_ORD_WR,
    S_ORD_END,
    S_TXT,
    S_FIN_SLOT,
    S_FIN_META
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/line_gap_buffer_editor_core.sv
// Top level of the line gap buffer editor: sequencer, byte mover and line tables.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | kind, character, line_number, read_column
//  out     | output    | out_valid_o/out_stall_i | status, cursor, lengths, read_byte
//  cfg     | input     | cfg_we_i              | cfg_wdata_i (visible_lines)
//
// After the accept, moves, goto and boundary cases run S_SLOT, S_META, S_EXEC,
// S_FIN_SLOT and S_FIN_META; read adds S_TXT and a move onto a neighboring line adds
// S_AUX_SLOT and S_AUX_META. Insert, backspace, split and join move each byte with a read
// and a write through the text RAM's read and write ports; split and join also shift order entries.
// Reset clears the tables at once through per-entry valid bits; no clearing pass.
// in_stall_o is high while a transaction is in work; a stalled result waits in
// the output register while the next transaction is taken.
`default_nettype none
module line_gap_buffer_editor_core #(
  parameter int unsigned MAX_LINES     = lgbe_pkg::MaxLinesDef,
  parameter int unsigned LINE_CAPACITY = lgbe_pkg::LineCapacityDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  kind_i,
  input  wire logic [7:0]  character_i,
  input  wire logic [15:0] line_number_i,
  input  wire logic [6:0]  read_column_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [5:0]       cursor_line_o,
  output logic [7:0]       cursor_column_o,
  output logic [7:0]       line_length_o,
  output logic [6:0]       line_count_o,
  output logic [6:0]       top_line_o,
  output logic [7:0]       read_byte_o,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i
);

  localparam int unsigned LW  = $clog2(MAX_LINES);
  localparam int unsigned LNW = $clog2(MAX_LINES + 1);
  localparam int unsigned CW  = $clog2(LINE_CAPACITY + 1);
  localparam int unsigned TD  = MAX_LINES * LINE_CAPACITY;
  localparam int unsigned TAW = $clog2(TD);
  localparam logic [CW-1:0]  Cap  = CW'(LINE_CAPACITY);
  localparam logic [LNW-1:0] MaxL = LNW'(MAX_LINES);

  // RAM ports
  logic           o_we, o_re, m_we, m_re, t_we, t_re;
  logic [LW-1:0]  o_waddr, o_raddr, o_wdata, o_rdata, m_waddr, m_raddr;
  logic [2*CW-1:0] m_wdata, m_rdata;
  logic [TAW-1:0] t_waddr, t_raddr;
  logic [7:0]     t_wdata, t_rdata;

  logic [MAX_LINES-1:0] ov_q, mv_q;
  logic           o_vld_q, m_vld_q;
  logic [LW-1:0]  o_ra_q;

  logic           m_re_all;
  logic [LW-1:0]  m_raddr_all;

  lgbe_ram #(.WIDTH(LW), .DEPTH(MAX_LINES)) u_order (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );
  lgbe_ram #(.WIDTH(2*CW), .DEPTH(MAX_LINES)) u_meta (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .re_i(m_re_all), .raddr_i(m_raddr_all), .rdata_o(m_rdata)
  );
  lgbe_ram #(.WIDTH(8), .DEPTH(TD)) u_text (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .re_i(t_re), .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  // unwritten order entries read as identity, unwritten meta as zero
  logic [LW-1:0] ord_eff;
  logic [CW-1:0] mlen, mcol;
  assign ord_eff = o_vld_q ? o_rdata : o_ra_q;
  assign mlen    = m_vld_q ? m_rdata[2*CW-1:CW] : '0;
  assign mcol    = m_vld_q ? m_rdata[CW-1:0] : '0;

  lgbe_pkg::state_e  state_q, state_d;
  lgbe_pkg::kind_e   kind_q, kind_d;
  lgbe_pkg::status_e status_q, status_d;
  logic [7:0]     ch_q, ch_d, vis_q, vis_d, rbyte_q, rbyte_d;
  logic [15:0]    tgt_q, tgt_d;
  logic [6:0]     rcol_q, rcol_d;
  logic [LW-1:0]  cur_q, cur_d, slot_q, slot_d, aux_q, aux_d, k_q, k_d;
  logic [LNW-1:0] lines_q, lines_d, top_q, top_d;
  logic [CW-1:0]  len_q, len_d, col_q, col_d, alen_q, alen_d, take_q, take_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [TAW-1:0] src_q, src_d, dst_q, dst_d;
  logic           up_q, up_d;

  logic           ov_q_o_vld, out_load;
  logic           out_valid_q;
  logic [1:0]     o_status_q;
  logic [5:0]     o_line_q;
  logic [7:0]     o_col_q, o_len_q, o_rbyte_q;
  logic [6:0]     o_count_q, o_top_q;

  function automatic logic [TAW-1:0] base(input logic [LW-1:0] s);
    return TAW'(TAW'(s) * TAW'(LINE_CAPACITY));
  endfunction

  // goto arithmetic
  logic [LNW-1:0] g_t;
  logic [15:0]    g_half;
  always_comb begin
    if (tgt_q > 16'(lines_q)) begin
      g_t = lines_q;
    end else if (tgt_q == '0) begin
      g_t = LNW'(1);
    end else begin
      g_t = LNW'(tgt_q);
    end
    g_half = 16'(vis_q[7:1]);
  end

  assign ov_q_o_vld = ov_q[o_raddr];

  always_comb begin
    state_d = state_q; kind_d = kind_q; status_d = status_q;
    ch_d = ch_q; vis_d = vis_q; rbyte_d = rbyte_q; tgt_d = tgt_q; rcol_d = rcol_q;
    cur_d = cur_q; slot_d = slot_q; aux_d = aux_q; k_d = k_q;
    lines_d = lines_q; top_d = top_q; len_d = len_q; col_d = col_q;
    alen_d = alen_q; take_d = take_q; cnt_d = cnt_q;
    src_d = src_q; dst_d = dst_q; up_d = up_q;
    o_we = 1'b0; o_re = 1'b0; o_waddr = '0; o_wdata = '0; o_raddr = cur_q;
    m_we = 1'b0; m_re = 1'b0; m_waddr = '0; m_wdata = '0; m_raddr = slot_q;
    t_we = 1'b0; t_re = 1'b0; t_waddr = '0; t_wdata = '0; t_raddr = src_q;
    if (cfg_we_i) begin
      vis_d = cfg_wdata_i;
    end
    unique case (state_q)
      lgbe_pkg::S_IDLE: begin
        if (in_valid_i) begin
          kind_d = lgbe_pkg::kind_e'(kind_i);
          ch_d = character_i; tgt_d = line_number_i; rcol_d = read_column_i;
          status_d = lgbe_pkg::STAT_DONE; rbyte_d = '0;
          o_re = 1'b1; o_raddr = cur_q;
          state_d = lgbe_pkg::S_SLOT;
        end
      end
      lgbe_pkg::S_SLOT: begin
        slot_d = ord_eff; m_re = 1'b1; m_raddr = ord_eff;
        state_d = lgbe_pkg::S_META;
      end
      lgbe_pkg::S_META: begin
        len_d = mlen; col_d = mcol;
        state_d = lgbe_pkg::S_EXEC;
      end
      lgbe_pkg::S_EXEC: begin
        state_d = lgbe_pkg::S_FIN_SLOT;
        unique case (kind_q)
          lgbe_pkg::KIND_INSERT: begin
            if (len_q >= Cap) begin
              status_d = lgbe_pkg::STAT_FULL;
            end else if (len_q > col_q) begin
              src_d = base(slot_q) + TAW'(len_q) - TAW'(1);
              dst_d = base(slot_q) + TAW'(len_q);
              cnt_d = len_q - col_q; up_d = 1'b0;
              state_d = lgbe_pkg::S_COPY_RD;
            end else begin
              state_d = lgbe_pkg::S_FIX;
            end
          end
          lgbe_pkg::KIND_BACKSPACE: begin
            if (col_q == '0) begin
              status_d = lgbe_pkg::STAT_EDGE;
            end else begin
              src_d = base(slot_q) + TAW'(col_q);
              dst_d = base(slot_q) + TAW'(col_q) - TAW'(1);
              cnt_d = len_q - col_q; up_d = 1'b1;
              state_d = (len_q != col_q) ? lgbe_pkg::S_COPY_RD : lgbe_pkg::S_FIX;
            end
          end
          lgbe_pkg::KIND_LEFT: begin
            if (col_q != '0) begin
              m_we = 1'b1; m_waddr = slot_q; m_wdata = {len_q, col_q - CW'(1)};
            end else if (cur_q != '0) begin
              cur_d = cur_q - LW'(1); o_re = 1'b1; o_raddr = cur_q - LW'(1);
              state_d = lgbe_pkg::S_AUX_SLOT;
            end else begin
              status_d = lgbe_pkg::STAT_EDGE;
            end
          end
          lgbe_pkg::KIND_RIGHT: begin
            if (col_q < len_q) begin
              m_we = 1'b1; m_waddr = slot_q; m_wdata = {len_q, col_q + CW'(1)};
            end else if (LNW'(cur_q) + LNW'(1) < lines_q) begin
              cur_d = cur_q + LW'(1); o_re = 1'b1; o_raddr = cur_q + LW'(1);
              state_d = lgbe_pkg::S_AUX_SLOT;
            end else begin
              status_d = lgbe_pkg::STAT_EDGE;
            end
          end
          lgbe_pkg::KIND_UP: begin
            if (cur_q != '0) cur_d = cur_q - LW'(1);
            else status_d = lgbe_pkg::STAT_EDGE;
          end
          lgbe_pkg::KIND_DOWN: begin
            if (LNW'(cur_q) + LNW'(1) < lines_q) cur_d = cur_q + LW'(1);
            else status_d = lgbe_pkg::STAT_EDGE;
          end
          lgbe_pkg::KIND_SPLIT: begin
            if (lines_q >= MaxL) begin
              status_d = lgbe_pkg::STAT_FULL;
            end else begin
              o_re = 1'b1; o_raddr = LW'(lines_q);
              state_d = lgbe_pkg::S_AUX_SLOT;
            end
          end
          lgbe_pkg::KIND_JOIN: begin
            if (cur_q == '0) begin
              status_d = lgbe_pkg::STAT_EDGE;
            end else begin
              o_re = 1'b1; o_raddr = cur_q - LW'(1);
              state_d = lgbe_pkg::S_AUX_SLOT;
            end
          end
          lgbe_pkg::KIND_GOTO: begin
            cur_d = LW'(g_t - LNW'(1));
            top_d = (16'(g_t) < g_half) ? '0 : LNW'(16'(g_t) - g_half);
          end
          lgbe_pkg::KIND_READ: begin
            if (CW'(rcol_q) < len_q && 8'(rcol_q) < 8'(LINE_CAPACITY)) begin
              t_re = 1'b1; t_raddr = base(slot_q) + TAW'(rcol_q);
              state_d = lgbe_pkg::S_TXT;
            end else begin
              status_d = lgbe_pkg::STAT_EDGE;
            end
          end
          default: status_d = lgbe_pkg::STAT_EDGE;
        endcase
      end
      lgbe_pkg::S_AUX_SLOT: begin
        aux_d = ord_eff; m_re = 1'b1; m_raddr = ord_eff;
        state_d = lgbe_pkg::S_AUX_META;
      end
      lgbe_pkg::S_AUX_META: begin
        alen_d = mlen;
        state_d = lgbe_pkg::S_FIN_SLOT;
        if (kind_q == lgbe_pkg::KIND_LEFT) begin
          m_we = 1'b1; m_waddr = aux_q; m_wdata = {mlen, mlen};
        end else if (kind_q == lgbe_pkg::KIND_RIGHT) begin
          m_we = 1'b1; m_waddr = aux_q; m_wdata = {mlen, CW'(0)};
        end else if (kind_q == lgbe_pkg::KIND_SPLIT) begin
          src_d = base(slot_q) + TAW'(col_q); dst_d = base(aux_q);
          cnt_d = len_q - col_q; up_d = 1'b1;
          state_d = (len_q != col_q) ? lgbe_pkg::S_COPY_RD : lgbe_pkg::S_FIX;
        end else begin
          // join: append up to the free room of the previous line
          take_d = (len_q > Cap - mlen) ? Cap - mlen : len_q;
          src_d = base(slot_q); dst_d = base(aux_q) + TAW'(mlen);
          cnt_d = (len_q > Cap - mlen) ? Cap - mlen : len_q; up_d = 1'b1;
          state_d = ((len_q > Cap - mlen) ? Cap - mlen : len_q) != '0 ?
                    lgbe_pkg::S_COPY_RD : lgbe_pkg::S_FIX;
        end
      end
      lgbe_pkg::S_COPY_RD: begin
        t_re = 1'b1; t_raddr = src_q;
        state_d = lgbe_pkg::S_COPY_WR;
      end
      lgbe_pkg::S_COPY_WR: begin
        t_we = 1'b1; t_waddr = dst_q; t_wdata = t_rdata;
        src_d = up_q ? src_q + TAW'(1) : src_q - TAW'(1);
        dst_d = up_q ? dst_q + TAW'(1) : dst_q - TAW'(1);
        cnt_d = cnt_q - CW'(1);
        state_d = (cnt_q == CW'(1)) ? lgbe_pkg::S_FIX : lgbe_pkg::S_COPY_RD;
      end
      lgbe_pkg::S_FIX: begin
        state_d = lgbe_pkg::S_FIN_SLOT;
        m_we = 1'b1;
        if (kind_q == lgbe_pkg::KIND_INSERT) begin
          t_we = 1'b1; t_waddr = base(slot_q) + TAW'(col_q); t_wdata = ch_q;
          m_waddr = slot_q; m_wdata = {len_q + CW'(1), col_q + CW'(1)};
        end else if (kind_q == lgbe_pkg::KIND_BACKSPACE) begin
          m_waddr = slot_q; m_wdata = {len_q - CW'(1), col_q - CW'(1)};
        end else if (kind_q == lgbe_pkg::KIND_SPLIT) begin
          m_waddr = aux_q; m_wdata = {len_q - col_q, CW'(0)};
          state_d = lgbe_pkg::S_FIX2;
        end else begin
          m_waddr = aux_q; m_wdata = {alen_q + take_q, alen_q};
          k_d = cur_q;
          state_d = (LNW'(cur_q) + LNW'(1) < lines_q) ? lgbe_pkg::S_ORD_RD :
                    lgbe_pkg::S_ORD_END;
        end
      end
      lgbe_pkg::S_FIX2: begin
        m_we = 1'b1; m_waddr = slot_q; m_wdata = {col_q, col_q};
        k_d = LW'(lines_q);
        state_d = (lines_q > LNW'(cur_q) + LNW'(1)) ? lgbe_pkg::S_ORD_RD :
                  lgbe_pkg::S_ORD_END;
      end
      lgbe_pkg::S_ORD_RD: begin
        o_re = 1'b1;
        o_raddr = (kind_q == lgbe_pkg::KIND_SPLIT) ? k_q - LW'(1) : k_q + LW'(1);
        state_d = lgbe_pkg::S_ORD_WR;
      end
      lgbe_pkg::S_ORD_WR: begin
        o_we = 1'b1; o_waddr = k_q; o_wdata = ord_eff;
        if (kind_q == lgbe_pkg::KIND_SPLIT) begin
          k_d = k_q - LW'(1);
          state_d = (LNW'(k_q) > LNW'(cur_q) + LNW'(2)) ? lgbe_pkg::S_ORD_RD :
                    lgbe_pkg::S_ORD_END;
        end else begin
          k_d = k_q + LW'(1);
          state_d = (LNW'(k_q) + LNW'(2) < lines_q) ? lgbe_pkg::S_ORD_RD :
                    lgbe_pkg::S_ORD_END;
        end
      end
      lgbe_pkg::S_ORD_END: begin
        o_we = 1'b1;
        if (kind_q == lgbe_pkg::KIND_SPLIT) begin
          o_waddr = cur_q + LW'(1); o_wdata = aux_q;
          lines_d = lines_q + LNW'(1); cur_d = cur_q + LW'(1);
        end else begin
          o_waddr = LW'(lines_q - LNW'(1)); o_wdata = slot_q;
          lines_d = lines_q - LNW'(1); cur_d = cur_q - LW'(1);
        end
        state_d = lgbe_pkg::S_FIN_SLOT;
      end
      lgbe_pkg::S_TXT: begin
        rbyte_d = t_rdata;
        state_d = lgbe_pkg::S_FIN_SLOT;
      end
      lgbe_pkg::S_FIN_SLOT: begin
        o_re = 1'b1; o_raddr = cur_q;
        state_d = lgbe_pkg::S_FIN_META;
      end
      lgbe_pkg::S_FIN_META: begin
        state_d = lgbe_pkg::S_FIN_META;
      end
      default: state_d = lgbe_pkg::S_IDLE;
    endcase
  end

  // final meta lookup: the order read in S_FIN_SLOT, then the meta read in S_FIN_META;
  // then the result waits here until the output register is free
  logic fin_rd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_rd_q <= 1'b0;
    end else if (state_q == lgbe_pkg::S_FIN_META) begin
      fin_rd_q <= ~out_load;
    end else begin
      fin_rd_q <= 1'b0;
    end
  end

  // meta read port for the final lookup is driven here to keep the case simple
  logic fin_m_re;
  assign fin_m_re = (state_q == lgbe_pkg::S_FIN_META) && !fin_rd_q;
  assign out_load = (state_q == lgbe_pkg::S_FIN_META) && fin_rd_q &&
                    (!out_valid_q || !out_stall_i);

  assign m_re_all    = m_re | fin_m_re;
  assign m_raddr_all = fin_m_re ? ord_eff : m_raddr;

  lgbe_pkg::state_e state_n;
  assign state_n = out_load ? lgbe_pkg::S_IDLE : state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgbe_pkg::S_IDLE;
      kind_q <= lgbe_pkg::KIND_INSERT; status_q <= lgbe_pkg::STAT_DONE;
      ch_q <= '0; vis_q <= lgbe_pkg::VisLinesReset; rbyte_q <= '0;
      tgt_q <= '0; rcol_q <= '0; cur_q <= '0; slot_q <= '0; aux_q <= '0; k_q <= '0;
      lines_q <= LNW'(1); top_q <= '0; len_q <= '0; col_q <= '0;
      alen_q <= '0; take_q <= '0; cnt_q <= '0; src_q <= '0; dst_q <= '0; up_q <= 1'b0;
      ov_q <= '0; mv_q <= '0; o_vld_q <= 1'b0; m_vld_q <= 1'b0; o_ra_q <= '0;
    end else begin
      state_q <= state_n;
      kind_q <= kind_d; status_q <= status_d; ch_q <= ch_d; vis_q <= vis_d;
      rbyte_q <= rbyte_d; tgt_q <= tgt_d; rcol_q <= rcol_d; cur_q <= cur_d;
      slot_q <= slot_d; aux_q <= aux_d; k_q <= k_d; lines_q <= lines_d; top_q <= top_d;
      len_q <= len_d; col_q <= col_d; alen_q <= alen_d; take_q <= take_d;
      cnt_q <= cnt_d; src_q <= src_d; dst_q <= dst_d; up_q <= up_d;
      if (o_we) ov_q[o_waddr] <= 1'b1;
      if (m_we) mv_q[m_waddr] <= 1'b1;
      if (o_re) begin
        o_vld_q <= ov_q_o_vld;
        o_ra_q  <= o_raddr;
      end
      if (m_re_all) m_vld_q <= mv_q[m_raddr_all];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      o_status_q <= '0; o_line_q <= '0; o_col_q <= '0; o_len_q <= '0;
      o_count_q <= '0; o_top_q <= '0; o_rbyte_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        o_status_q  <= status_q;
        o_line_q    <= 6'(cur_q);
        o_col_q     <= 8'(mcol);
        o_len_q     <= 8'(mlen);
        o_count_q   <= 7'(lines_q);
        o_top_q     <= 7'(top_q);
        o_rbyte_q   <= rbyte_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_stall_o      = (state_q != lgbe_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign cursor_line_o   = o_line_q;
  assign cursor_column_o = o_col_q;
  assign line_length_o   = o_len_q;
  assign line_count_o    = o_count_q;
  assign top_line_o      = o_top_q;
  assign read_byte_o     = o_rbyte_q;

endmodule
`default_nettype wire

FILE: rtl/lgbe_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module lgbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/lgbe_checker.sv
// Port-level checks for the line gap buffer editor, bound to the top level.
`default_nettype none
module lgbe_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  status_o,
  input wire logic [5:0]  cursor_line_o,
  input wire logic [6:0]  line_count_o
);

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted transaction makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("not busy after accept");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status code");

  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, cursor_line_o} < line_count_o))
    else $error("cursor beyond document");

endmodule

bind line_gap_buffer_editor_core lgbe_checker u_lgbe_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .cursor_line_o, .line_count_o
);
`default_nettype wire
